// ----- hdl/page_framebuffer_with_chunked_flush_top_defines.svh -----
// Assertion macros shared by the frame buffer modules.
// Define ASSERT_OFF to compile every check away.
`ifndef PAGE_FRAMEBUFFER_WITH_CHUNKED_FLUSH_TOP_DEFINES_SVH
`define PAGE_FRAMEBUFFER_WITH_CHUNKED_FLUSH_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on the module's own clock and reset, which must be named clock and reset.
`define PFB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check on an explicitly named clock and reset.
`define PFB_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define PFB_ASSERT(lbl, prop, msg)
`define PFB_ASSERT_CLK(lbl, clk, rst, prop, msg)
`endif

`endif

// ----- hdl/pfb_pkg.sv -----
`timescale 1ns / 1ps

package pfb_pkg;

   // Request function codes carried in req_tuser.
   localparam logic [1:0] FUNC_SET   = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_FLUSH = 2'd2;

   // Result kinds carried in rsp_tuser.
   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_PREFIX = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;

   // Control byte that opens every flushed chunk.
   localparam logic [7:0] CTRL_DATA_PREFIX = 8'h40;

   // Register indexes on the configuration channel.
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // Register reset values.
   localparam logic [7:0] WIDTH_RESET  = 8'd128;
   localparam logic [6:0] HEIGHT_RESET = 7'd64;

   // Widths large enough for the biggest store the block supports
   // (256 columns by 16 pages).
   localparam int STORE_ADDR_W = 12;
   localparam int FRAME_SIZE_W = 13;

   // Depth of the command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCOUNT_W    = 3;

   // Classified commands handed from the front to the back.
   typedef enum logic [1:0] {
      CMD_ACK   = 2'd0,
      CMD_SET   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type                op;
      logic [FRAME_SIZE_W-1:0]   size;
      logic [STORE_ADDR_W-1:0]   addr;
      logic [2:0]                bit_sel;
      logic                      pixel_on;
   } cmd_type;

endpackage

// ----- hdl/pfb_queue.sv -----
`timescale 1ns / 1ps
`include "page_framebuffer_with_chunked_flush_top_defines.svh"

module pfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pfb_pkg::cmd_type push_cmd,
   input  logic             pop,
   output pfb_pkg::cmd_type head_cmd,
   output logic             empty,
   output logic             full
);

   pfb_pkg::cmd_type                   slot_ff [pfb_pkg::QUEUE_DEPTH];
   logic [pfb_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [pfb_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [pfb_pkg::QCOUNT_W-1:0]       count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == pfb_pkg::QCOUNT_W'(pfb_pkg::QUEUE_DEPTH));
   assign head_cmd = slot_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `PFB_ASSERT_CLK(a_no_push_when_full, clock, reset, push |-> !full,
      "command pushed into a full queue")
   `PFB_ASSERT_CLK(a_no_pop_when_empty, clock, reset, pop |-> !empty,
      "command popped from an empty queue")
   `PFB_ASSERT_CLK(a_count_tracks, clock, reset, (push && !pop) |=> !empty,
      "queue empty right after a push")

endmodule

// ----- hdl/pfb_front.sv -----
`timescale 1ns / 1ps

module pfb_front #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_PAGES   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,
   input  logic [1:0]       req_tuser,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [7:0]       csr_data,
   input  logic             queue_full,
   input  logic             init_busy,
   output logic             push,
   output pfb_pkg::cmd_type push_cmd
);

   logic [7:0] width_ff, width_in;
   logic [6:0] height_ff, height_in;

   logic [8:0] eff_width;
   logic [7:0] eff_height;
   logic [7:0] height_round;
   logic [4:0] pages;
   logic [7:0] pix_x;
   logic [7:0] pix_y;
   logic       pix_on;
   logic       in_range;
   logic [pfb_pkg::FRAME_SIZE_W-1:0] frame_size;
   logic [pfb_pkg::FRAME_SIZE_W-1:0] pixel_addr;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full && !init_busy;
   assign push       = req_tvalid && req_tready;

   assign pix_x  = req_tdata[7:0];
   assign pix_y  = req_tdata[15:8];
   assign pix_on = req_tdata[16];

   // Configuration registers.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pfb_pkg::CSR_WIDTH: begin
               width_in = csr_data;
            end
            pfb_pkg::CSR_HEIGHT: begin
               height_in = csr_data[6:0];
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pfb_pkg::WIDTH_RESET;
         height_ff <= pfb_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Saturate the geometry to what the store can hold.
   always_comb begin
      if (width_ff == 8'd0) begin
         eff_width = 9'd1;
      end else if ({1'b0, width_ff} > 9'(MAX_COLUMNS)) begin
         eff_width = 9'(MAX_COLUMNS);
      end else begin
         eff_width = {1'b0, width_ff};
      end
      if (height_ff == 7'd0) begin
         eff_height = 8'd1;
      end else if ({1'b0, height_ff} > 8'(MAX_PAGES * 8)) begin
         eff_height = 8'(MAX_PAGES * 8);
      end else begin
         eff_height = {1'b0, height_ff};
      end
   end

   assign height_round = eff_height + 8'd7;
   assign pages        = height_round[7:3];
   assign frame_size   = pfb_pkg::FRAME_SIZE_W'(eff_width)
                       * pfb_pkg::FRAME_SIZE_W'(pages);

   // Byte address of the pixel: column plus page times width.
   assign pixel_addr = pfb_pkg::FRAME_SIZE_W'(pix_x)
                     + pfb_pkg::FRAME_SIZE_W'(pix_y[7:3])
                       * pfb_pkg::FRAME_SIZE_W'(eff_width);
   assign in_range   = ({1'b0, pix_x} < eff_width) && ({1'b0, pix_y} < {1'b0, eff_height});

   // Classify the item into a command for the back.
   always_comb begin
      push_cmd.size     = frame_size;
      push_cmd.addr     = pixel_addr[pfb_pkg::STORE_ADDR_W-1:0];
      push_cmd.bit_sel  = pix_y[2:0];
      push_cmd.pixel_on = pix_on;
      case (req_tuser)
         pfb_pkg::FUNC_SET: begin
            push_cmd.op = in_range ? pfb_pkg::CMD_SET : pfb_pkg::CMD_ACK;
         end
         pfb_pkg::FUNC_CLEAR: begin
            push_cmd.op = pfb_pkg::CMD_CLEAR;
         end
         pfb_pkg::FUNC_FLUSH: begin
            push_cmd.op = pfb_pkg::CMD_FLUSH;
         end
         default: begin
            push_cmd.op = pfb_pkg::CMD_ACK;
         end
      endcase
   end

endmodule

// ----- hdl/pfb_back.sv -----
`timescale 1ns / 1ps
`include "page_framebuffer_with_chunked_flush_top_defines.svh"

module pfb_back #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_PAGES   = 8,
   parameter int CHUNK_BYTES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  pfb_pkg::cmd_type head_cmd,
   input  logic             queue_empty,
   output logic             pop,
   output logic             init_busy,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   localparam int STORE_BYTES = MAX_COLUMNS * MAX_PAGES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int SZ_W        = $clog2(STORE_BYTES + 1);
   localparam int CNT_W       = $clog2(CHUNK_BYTES + 1);

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_SET    = 7'b0000100,
      ST_CLEAR  = 7'b0001000,
      ST_ACK    = 7'b0010000,
      ST_PREFIX = 7'b0100000,
      ST_DATA   = 7'b1000000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [SZ_W-1:0]    cnt_ff, cnt_in;
   logic [SZ_W-1:0]    size_ff, size_in;
   logic [SZ_W-1:0]    offset_ff, offset_in;
   logic [SZ_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               done_ff, done_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [2:0]         bit_ff, bit_in;
   logic               on_ff, on_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         kind_ff, kind_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               frame_done_ff, frame_done_in;

   logic [7:0]         frame_store_ff [STORE_BYTES];
   logic [7:0]         rd_data_ff;

   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic               out_free;
   logic [7:0]         bit_mask;
   logic [SZ_W-1:0]    start;
   logic [SZ_W-1:0]    remaining;
   logic               chunk_fits;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign init_busy  = (state_ff == ST_INIT);
   assign pop        = (state_ff == ST_IDLE) && !queue_empty;
   assign bit_mask   = 8'h01 << bit_ff;

   // A stale flush pointer restarts at the top of the frame.
   assign start      = (offset_ff >= size_ff) ? '0 : offset_ff;
   assign remaining  = size_ff - start;
   assign chunk_fits = (32'(remaining) <= 32'(CHUNK_BYTES));

   // Sequencer for the store and the result register.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      size_in       = size_ff;
      offset_in     = offset_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      done_in       = done_ff;
      addr_in       = addr_ff;
      bit_in        = bit_ff;
      on_in         = on_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      kind_in       = kind_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      frame_done_in = frame_done_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[ADDR_W-1:0];
      wr_data       = 8'h00;

      case (state_ff)
         ST_INIT: begin
            // Zero the whole store after reset, one byte a cycle.
            wr_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SZ_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               size_in = head_cmd.size[SZ_W-1:0];
               addr_in = head_cmd.addr[ADDR_W-1:0];
               bit_in  = head_cmd.bit_sel;
               on_in   = head_cmd.pixel_on;
               cnt_in  = '0;
               case (head_cmd.op)
                  pfb_pkg::CMD_SET: begin
                     rd_en    = 1'b1;
                     rd_addr  = head_cmd.addr[ADDR_W-1:0];
                     state_in = ST_SET;
                  end
                  pfb_pkg::CMD_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  pfb_pkg::CMD_FLUSH: begin
                     state_in = ST_PREFIX;
                  end
                  default: begin
                     state_in = ST_ACK;
                  end
               endcase
            end
         end
         ST_SET: begin
            // Write back the modified byte together with the acknowledge.
            if (out_free) begin
               wr_en         = 1'b1;
               wr_addr       = addr_ff;
               wr_data       = on_ff ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
               rsp_valid_in  = 1'b1;
               kind_in       = pfb_pkg::KIND_ACK;
               byte_in       = 8'h00;
               last_in       = 1'b1;
               frame_done_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff + 1'b1 == size_ff) begin
               state_in = ST_ACK;
            end
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               kind_in       = pfb_pkg::KIND_ACK;
               byte_in       = 8'h00;
               last_in       = 1'b1;
               frame_done_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_PREFIX: begin
            // The frame is never empty, so a data byte always follows.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               kind_in       = pfb_pkg::KIND_PREFIX;
               byte_in       = pfb_pkg::CTRL_DATA_PREFIX;
               last_in       = 1'b0;
               frame_done_in = 1'b0;
               ptr_in        = start;
               left_in       = chunk_fits ? CNT_W'(remaining) : CNT_W'(CHUNK_BYTES);
               done_in       = chunk_fits;
               rd_en         = 1'b1;
               rd_addr       = start[ADDR_W-1:0];
               state_in      = ST_DATA;
            end
         end
         ST_DATA: begin
            // Send the fetched byte and fetch the next one in the same cycle.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               kind_in       = pfb_pkg::KIND_DATA;
               byte_in       = rd_data_ff;
               last_in       = (left_ff == CNT_W'(1));
               frame_done_in = (left_ff == CNT_W'(1)) && done_ff;
               ptr_in        = ptr_ff + 1'b1;
               left_in       = left_ff - 1'b1;
               if (left_ff == CNT_W'(1)) begin
                  offset_in = done_ff ? '0 : ptr_ff + 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_in[ADDR_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_INIT;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers carry no reset.
   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      done_ff       <= done_in;
      addr_ff       <= addr_in;
      bit_ff        <= bit_in;
      on_ff         <= on_in;
      kind_ff       <= kind_in;
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      frame_done_ff <= frame_done_in;
   end

   // Frame store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= frame_store_ff[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, frame_done_ff, byte_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   `PFB_ASSERT(a_quiet_during_init, (state_ff == ST_INIT) |-> !rsp_valid_ff,
      "result offered while the store is still being cleared")
   `PFB_ASSERT(a_chunk_not_empty, (state_ff == ST_DATA) |-> (left_ff != '0),
      "flush data phase entered with no bytes left")
   `PFB_ASSERT(a_flush_in_frame, (state_ff == ST_DATA) |-> (ptr_ff < size_ff),
      "flush pointer ran past the end of the frame")

endmodule

// ----- hdl/page_framebuffer_with_chunked_flush_top.sv -----
`timescale 1ns / 1ps
// Page-organised monochrome frame buffer with chunked flush.
// Requests arrive on req_*: req_tuser is the function (set pixel, clear, flush
// chunk) and req_tdata carries x, y and pixel_on. Results leave on rsp_*:
// rsp_tuser is the kind, rsp_tdata the bus byte and frame-done flag, and
// rsp_tlast marks the final result of each request. csr_* writes the display
// width (index 0) and height (index 1); it is always ready.
// A front stage classifies each item and queues it four deep; the back stage
// owns the store (one write port, one read port) and the result register.
// Set pixel: the back pops the item with a store read, then writes the byte
// back with the acknowledge, and takes no new item until it has done so.
// Clear: the bytes in use are zeroed one a cycle, then the acknowledge follows.
// Flush: prefix byte, then one data byte a cycle while the receiver is ready;
// the store's one read port sets that pace.
// After reset the back zeroes all MAX_COLUMNS * MAX_PAGES bytes, one a cycle;
// req_tready stays low for that time.
// A stalled receiver holds the result register; the back waits and the queue
// keeps taking items until it is full.
module page_framebuffer_with_chunked_flush_top #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_PAGES   = 8,
   parameter int CHUNK_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // x [7:0], y [15:8], pixel_on [16], zero fill
   input  logic [1:0]  req_tuser,   // func [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte [7:0], frame_done [8], zero fill
   output logic [1:0]  rsp_tuser,   // kind [1:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   pfb_pkg::cmd_type push_cmd;
   pfb_pkg::cmd_type head_cmd;
   logic             push;
   logic             pop;
   logic             queue_empty;
   logic             queue_full;
   logic             init_busy;

   pfb_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_PAGES   (MAX_PAGES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .init_busy  (init_busy),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   pfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   pfb_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_PAGES   (MAX_PAGES),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .pop         (pop),
      .init_busy   (init_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ----- bench/framebuffer_bus_check.sv -----
`timescale 1ns / 1ps

module framebuffer_bus_check #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_PAGES   = 8,
   parameter int CHUNK_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // x [7:0], y [15:8], pixel_on [16], zero fill
   input  logic [1:0]  req_tuser,   // func [1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // out_byte [7:0], frame_done [8], zero fill
   input  logic [1:0]  rsp_tuser,   // kind [1:0]
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending_count
);

   localparam int STORE_BYTES = MAX_COLUMNS * MAX_PAGES;

   // One item as it should leave on the result channel.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] bus_byte;
      logic       last;
      logic       frame_done;
   } bus_item_type;

   // Our own copy of the frame store, flush pointer and registers.
   logic [7:0]  pixel_pages [STORE_BYTES];
   int unsigned flush_ptr;
   logic [7:0]  width_reg;
   logic [6:0]  height_reg;

   bus_item_type bytes_due [$];
   int           errors_seen = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Registers are saturated to the supported store before use.
   function automatic int unsigned cols_in_use();
      if (width_reg == 8'd0) return 1;
      if (width_reg > MAX_COLUMNS) return MAX_COLUMNS;
      return width_reg;
   endfunction

   function automatic int unsigned rows_in_use();
      if (height_reg == 7'd0) return 1;
      if (height_reg > MAX_PAGES * 8) return MAX_PAGES * 8;
      return height_reg;
   endfunction

   // Update the store for one request and queue the bus items it should cause.
   task automatic apply_request(input logic [1:0] func, input logic [7:0] x,
                                input logic [7:0] y, input logic pixel_on);
      int unsigned cols, rows, size, idx, count, i;
      logic        done, fin;
      logic [7:0]  data_byte;
      cols = cols_in_use();
      rows = rows_in_use();
      size = cols * ((rows + 7) / 8);
      case (func)
         pfb_pkg::FUNC_SET: begin
            // Pixels outside the display leave the store alone but are still acknowledged.
            if (x < cols && y < rows) begin
               idx = x + (y / 8) * cols;
               if (idx < STORE_BYTES) pixel_pages[idx][y[2:0]] = pixel_on;
            end
            bytes_due.push_back('{pfb_pkg::KIND_ACK, 8'd0, 1'b1, 1'b0});
         end
         pfb_pkg::FUNC_CLEAR: begin
            // Only the bytes in use are zeroed; the flush pointer stays put.
            for (i = 0; i < size && i < STORE_BYTES; i++) pixel_pages[i] = 8'd0;
            bytes_due.push_back('{pfb_pkg::KIND_ACK, 8'd0, 1'b1, 1'b0});
         end
         pfb_pkg::FUNC_FLUSH: begin
            // A pointer left beyond a shrunken frame restarts at zero.
            if (flush_ptr >= size) flush_ptr = 0;
            count = size - flush_ptr;
            if (count > CHUNK_BYTES) count = CHUNK_BYTES;
            done = (flush_ptr + count) >= size;
            bytes_due.push_back('{pfb_pkg::KIND_PREFIX, pfb_pkg::CTRL_DATA_PREFIX,
                                  count == 0, count == 0 && done});
            for (i = 0; i < count; i++) begin
               idx       = flush_ptr + i;
               data_byte = (idx < STORE_BYTES) ? pixel_pages[idx] : 8'd0;
               fin       = (i + 1 == count);
               bytes_due.push_back('{pfb_pkg::KIND_DATA, data_byte, fin, fin && done});
            end
            flush_ptr = done ? 0 : flush_ptr + count;
         end
         default: begin
            // The unused function code only gets an acknowledge.
            bytes_due.push_back('{pfb_pkg::KIND_ACK, 8'd0, 1'b1, 1'b0});
         end
      endcase
   endtask

   // Track register writes and requests, then compare each result item in order.
   always @(posedge clock) begin
      bus_item_type want;
      if (reset) begin
         foreach (pixel_pages[i]) pixel_pages[i] = 8'd0;
         flush_ptr  = 0;
         width_reg  = pfb_pkg::WIDTH_RESET;
         height_reg = pfb_pkg::HEIGHT_RESET;
         bytes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == pfb_pkg::CSR_WIDTH) width_reg = csr_data;
            else height_reg = csr_data[6:0];
         end
         if (req_tvalid && req_tready)
            apply_request(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[16]);
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               $error("unexpected result item: kind %0d, out_byte 0x%02h", rsp_tuser,
                      rsp_tdata[7:0]);
               errors_seen++;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_tuser);
                  errors_seen++;
               end
               if (rsp_tdata[7:0] !== want.bus_byte) begin
                  $error("out_byte: expected 0x%02h, actual 0x%02h", want.bus_byte,
                         rsp_tdata[7:0]);
                  errors_seen++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
                  errors_seen++;
               end
               if (rsp_tdata[8] !== want.frame_done) begin
                  $error("frame_done: expected %0b, actual %0b", want.frame_done,
                         rsp_tdata[8]);
                  errors_seen++;
               end
            end
         end
      end
      pending_count <= bytes_due.size();
      fail_count    <= errors_seen;
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

   // Function code the block does not use; it must still be acknowledged.
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // x [7:0], y [15:8], pixel_on [16], zero fill
   logic [1:0]  req_tuser  = '0;   // func [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // out_byte [7:0], frame_done [8], zero fill
   logic [1:0]  rsp_tuser;         // kind [1:0]
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [7:0]  csr_data   = '0;

   int          fail_count;
   int          pending_count;
   logic        calm = 1'b0;

   always #5 clock = ~clock;

   page_framebuffer_with_chunked_flush_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   framebuffer_bus_check bus_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Offer one request item, sometimes after a burst of idle cycles.
   task automatic send_item(input logic [1:0] func, input logic [7:0] x,
                            input logic [7:0] y, input logic pixel_on);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'd0, pixel_on, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and wait until every expected result item has left the block.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   // Write both display registers; only called while the block is idle.
   task automatic set_display(input logic [7:0] width, input logic [7:0] height);
      csr_valid <= 1'b1;
      csr_index <= pfb_pkg::CSR_WIDTH;
      csr_data  <= width;
      do @(posedge clock); while (!csr_ready);
      csr_index <= pfb_pkg::CSR_HEIGHT;
      csr_data  <= height;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One random request, mostly pixel writes inside the display and flushes.
   task automatic random_item(input int cols, input int rows);
      int         pick;
      logic [7:0] x, y;
      logic       on;
      pick = $urandom_range(0, 99);
      x    = 8'($urandom_range(0, 255));
      y    = 8'($urandom_range(0, 255));
      on   = 1'($urandom_range(0, 1));
      if (pick < 60) begin
         if ($urandom_range(0, 4) != 0) begin
            x = 8'($urandom_range(0, cols - 1));
            y = 8'($urandom_range(0, rows - 1));
         end
         send_item(pfb_pkg::FUNC_SET, x, y, on);
      end else if (pick < 90) begin
         send_item(pfb_pkg::FUNC_FLUSH, x, y, on);
      end else if (pick < 96) begin
         send_item(pfb_pkg::FUNC_CLEAR, x, y, on);
      end else begin
         send_item(FUNC_SPARE, x, y, on);
      end
   endtask

   // The receiver stalls in random bursts until the closing phases.
   initial begin
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 25)) @(posedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      int w, h, cols, rows, phase, n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: corners, outside pixels, bit clear, spare code, flushes.
      send_item(pfb_pkg::FUNC_SET, 8'd0, 8'd0, 1'b1);
      send_item(pfb_pkg::FUNC_SET, 8'd127, 8'd63, 1'b1);
      send_item(pfb_pkg::FUNC_SET, 8'd128, 8'd0, 1'b1);
      send_item(pfb_pkg::FUNC_SET, 8'd0, 8'd64, 1'b1);
      send_item(pfb_pkg::FUNC_SET, 8'd255, 8'd255, 1'b1);
      send_item(pfb_pkg::FUNC_SET, 8'd5, 8'd9, 1'b1);
      send_item(pfb_pkg::FUNC_SET, 8'd5, 8'd9, 1'b0);
      send_item(pfb_pkg::FUNC_SET, 8'd6, 8'd9, 1'b1);
      send_item(FUNC_SPARE, 8'hAA, 8'h55, 1'b1);
      send_item(pfb_pkg::FUNC_FLUSH, 8'h55, 8'hAA, 1'b0);
      send_item(pfb_pkg::FUNC_FLUSH, 8'd0, 8'd0, 1'b0);
      drain_results();

      // A clear between flushes must not move the flush pointer.
      set_display(8'd40, 8'd16);
      send_item(pfb_pkg::FUNC_FLUSH, 8'd0, 8'd0, 1'b0);
      send_item(pfb_pkg::FUNC_FLUSH, 8'd0, 8'd0, 1'b0);
      send_item(pfb_pkg::FUNC_CLEAR, 8'd0, 8'd0, 1'b0);
      send_item(pfb_pkg::FUNC_SET, 8'd3, 8'd15, 1'b1);
      send_item(pfb_pkg::FUNC_FLUSH, 8'd0, 8'd0, 1'b0);
      drain_results();

      // The frame shrinks below the flush pointer, which must restart at zero.
      set_display(8'd10, 8'd8);
      send_item(pfb_pkg::FUNC_FLUSH, 8'd0, 8'd0, 1'b0);
      drain_results();

      // Zero registers saturate to a single byte frame.
      set_display(8'd0, 8'd0);
      send_item(pfb_pkg::FUNC_SET, 8'd0, 8'd0, 1'b1);
      send_item(pfb_pkg::FUNC_SET, 8'd1, 8'd0, 1'b1);
      send_item(pfb_pkg::FUNC_SET, 8'd0, 8'd1, 1'b1);
      send_item(pfb_pkg::FUNC_FLUSH, 8'd0, 8'd0, 1'b0);
      send_item(pfb_pkg::FUNC_CLEAR, 8'd0, 8'd0, 1'b0);
      send_item(pfb_pkg::FUNC_FLUSH, 8'd0, 8'd0, 1'b0);
      drain_results();

      // Random phases, each with its own geometry; mostly small frames.
      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin
               w = 255;
               h = 255;
            end
            1: begin
               w = 1;
               h = 1;
            end
            2: begin
               w = 128;
               h = 64;
            end
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  w = $urandom_range(0, 255);
                  h = $urandom_range(0, 255);
               end else begin
                  w = $urandom_range(1, 24);
                  h = $urandom_range(1, 24);
               end
            end
         endcase
         calm = (phase >= 7);
         set_display(w[7:0], h[7:0]);
         cols = (w == 0) ? 1 : (w > 128 ? 128 : w);
         rows = (h[6:0] == 0) ? 1 : (h[6:0] > 64 ? 64 : h[6:0]);
         for (n = 0; n < 27; n++) random_item(cols, rows);
         drain_results();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Give up if the run hangs.
   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
